FILE: rtl/lvf_pkg.sv
// Package: shared constants and types for the linear volume fade block.
`default_nettype none
package lvf_pkg;

   // Progress is Q0.16; one is 1 << PROG_BITS and needs one extra bit.
   localparam int PROG_BITS      = 16;
   localparam int PROG_W         = PROG_BITS + 1;
   localparam logic [PROG_W-1:0] PROG_ONE = PROG_W'(1) << PROG_BITS;

   // One quotient bit per divider step.
   localparam int DIV_STEPS      = PROG_W;
   localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

   // Field and register widths.
   localparam int LEVEL_BITS     = 16;
   localparam int ELAPSED_BITS   = 16;
   localparam int DURATION_BITS  = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_MODE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_DURATION = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_LEVEL   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_LEVEL  = 2'd3;

   // Request and mode codes.
   localparam logic REQ_TICK      = 1'b0;
   localparam logic REQ_START     = 1'b1;
   localparam logic MODE_FADE_IN  = 1'b0;
   localparam logic MODE_FADE_OUT = 1'b1;

   // Divider status toward the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } lvf_div_status_type;

endpackage
`default_nettype wire

FILE: rtl/lvf_req_if.sv
// Interface: request channel carrying tick and start beats.
`default_nettype none
interface lvf_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] elapsed;

   modport source (output valid, output req_type, output elapsed, input ready);
   modport sink   (input valid, input req_type, input elapsed, output ready);
endinterface
`default_nettype wire

FILE: rtl/lvf_rsp_if.sv
// Interface: response channel carrying the current volume beats.
`default_nettype none
interface lvf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] level;
   logic        finished;
   logic        busy_res;

   modport source (output valid, output level, output finished, output busy_res, input ready);
   modport sink   (input valid, input level, input finished, input busy_res, output ready);
endinterface
`default_nettype wire

FILE: rtl/lvf_div.sv
// Module: restoring divider producing the Q0.16 fade progress.
`default_nettype none
module lvf_div #(
   parameter int TIME_BITS = 24
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [TIME_BITS-1:0]       numer,
   input  wire logic [TIME_BITS-1:0]       denom,
   output logic [lvf_pkg::PROG_W-1:0]      quotient,
   output lvf_pkg::lvf_div_status_type     div_status
);
   import lvf_pkg::*;

   logic [TIME_BITS:0]        rem_ff, rem_in;
   logic [TIME_BITS-1:0]      den_ff, den_in;
   logic [PROG_W-1:0]         quo_ff, quo_in;
   logic [DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic                      ge;
   logic [TIME_BITS-1:0]      diff;

   // One quotient bit per cycle: subtract when it fits, then shift.
   // The remainder stays below the divisor, so the shifted value fits.
   always_comb begin
      ge   = (rem_ff >= {1'b0, den_ff});
      diff = ge ? TIME_BITS'(rem_ff - {1'b0, den_ff}) : TIME_BITS'(rem_ff);
   end

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, numer};
         den_in  = denom;
         quo_in  = '0;
         cnt_in  = DIV_CNT_BITS'(DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = {diff, 1'b0};
         quo_in = {quo_ff[PROG_W-2:0], ge};
         cnt_in = cnt_ff - DIV_CNT_BITS'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient        = quo_ff;
   assign div_status.busy = busy_ff;
   assign div_status.done = done_ff;

endmodule
`default_nettype wire

FILE: rtl/linear_volume_fade.sv
// Top level: linear volume fade ramp with sequencer, multiplier and config registers.
// Usage:
//  - req_bus carries beats of req_type (tick or start) and elapsed time units.
//  - rsp_bus returns one beat per request: level (Q1.15), finished, busy_res.
//  - csr_we/csr_index/csr_wdata write fade_mode, fade_duration, start_level
//    and target_level; write them only while the block is idle.
//  - A start beat, a tick while disarmed or a tick that finishes the fade
//    goes straight to ST_OUT, which loads the output register; the finishing tick
//    snaps the level to the target (fade in) or to zero (fade out).
//  - Any other tick runs the divider (one quotient bit a cycle), then takes
//    the quotient, multiplies, scales and loads the output register through
//    ST_DIV, ST_MUL, ST_SCALE and ST_OUT; the next request is accepted once
//    the sequencer is back in ST_IDLE.
//  - req_bus.ready is high only while the sequencer is idle and out of reset;
//    one request is worked on at a time.
//  - A finished response waits in the output register while the next request
//    is accepted and computed; a stalled receiver holds the block only when a
//    second response is ready to leave.
//  - Synchronous reset disarms the fade, clears timer and level, drops any
//    pending response and loads the register defaults.
`default_nettype none
module linear_volume_fade #(
   parameter int TIME_BITS       = 24,
   parameter int LEVEL_FRAC_BITS = 15
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   lvf_req_if.sink                                 req_bus,
   lvf_rsp_if.source                               rsp_bus,
   input  wire logic                               csr_we,
   input  wire logic [lvf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [lvf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import lvf_pkg::*;

   // Full scale in Q1.LEVEL_FRAC_BITS and the width needed to compare with it.
   localparam int LEVEL_ONE_W = LEVEL_FRAC_BITS + 1;
   localparam int CMP_W       = (LEVEL_ONE_W > LEVEL_BITS) ? LEVEL_ONE_W : LEVEL_BITS;
   localparam logic [CMP_W-1:0] LEVEL_ONE = CMP_W'(1) << LEVEL_FRAC_BITS;
   localparam int SUM_W       = ((TIME_BITS > ELAPSED_BITS) ? TIME_BITS : ELAPSED_BITS) + 1;
   localparam int PROD_W      = LEVEL_BITS + PROG_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_SCALE,
      ST_OUT
   } state_type;

   // Clamp a level to full scale.
   function automatic logic [LEVEL_BITS-1:0] clamp_level(input logic [LEVEL_BITS-1:0] v);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(v);
      clamp_level = (wide > LEVEL_ONE) ? LEVEL_BITS'(LEVEL_ONE) : v;
   endfunction

   // Configuration registers.
   logic                     fade_mode_ff;
   logic [DURATION_BITS-1:0] fade_duration_ff;
   logic [LEVEL_BITS-1:0]    start_level_ff;
   logic [LEVEL_BITS-1:0]    target_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_mode_ff     <= MODE_FADE_IN;
         fade_duration_ff <= DURATION_BITS'(1);
         start_level_ff   <= LEVEL_BITS'(32768);
         target_level_ff  <= LEVEL_BITS'(32768);
      end else if (csr_we) begin
         case (csr_index)
            CSR_FADE_MODE:     fade_mode_ff     <= csr_wdata[0];
            CSR_FADE_DURATION: fade_duration_ff <= csr_wdata[DURATION_BITS-1:0];
            CSR_START_LEVEL:   start_level_ff   <= csr_wdata[LEVEL_BITS-1:0];
            CSR_TARGET_LEVEL:  target_level_ff  <= csr_wdata[LEVEL_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer state and datapath registers.
   state_type               state_ff, state_in;
   logic [TIME_BITS-1:0]    time_acc_ff, time_acc_in;
   logic [LEVEL_BITS-1:0]   level_ff, level_in;
   logic                    armed_ff, armed_in;
   logic                    fin_ff, fin_in;
   logic [PROG_W-1:0]       prog_ff, prog_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0]   rsp_level_ff, rsp_level_in;
   logic                    rsp_fin_ff, rsp_fin_in;
   logic                    rsp_busy_ff, rsp_busy_in;

   logic [TIME_BITS-1:0]    dur;
   logic [SUM_W-1:0]        t_sum;
   logic [TIME_BITS-1:0]    t_sat;
   logic [LEVEL_BITS-1:0]   start_clamped;
   logic [LEVEL_BITS-1:0]   target_clamped;
   logic [LEVEL_BITS-1:0]   mul_level;
   logic [PROG_W-1:0]       mul_factor;
   logic                    div_start;
   logic [PROG_W-1:0]       div_quotient;
   lvf_div_status_type      div_status;

   // Saturate the accumulated time at the duration.
   always_comb begin
      dur            = TIME_BITS'(fade_duration_ff);
      t_sum          = SUM_W'(time_acc_ff) + SUM_W'(req_bus.elapsed);
      t_sat          = (t_sum > SUM_W'(dur)) ? dur : TIME_BITS'(t_sum);
      start_clamped  = clamp_level(start_level_ff);
      target_clamped = clamp_level(target_level_ff);
      // Fade in scales the target by progress, fade out the start by its complement.
      mul_level      = (fade_mode_ff == MODE_FADE_IN) ? target_clamped : start_clamped;
      mul_factor     = (fade_mode_ff == MODE_FADE_IN) ? prog_ff : PROG_ONE - prog_ff;
   end

   lvf_div #(
      .TIME_BITS (TIME_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .numer      (t_sat),
      .denom      (dur),
      .quotient   (div_quotient),
      .div_status (div_status)
   );

   always_comb begin
      state_in     = state_ff;
      time_acc_in  = time_acc_ff;
      level_in     = level_ff;
      armed_in     = armed_ff;
      fin_in       = fin_ff;
      prog_in      = prog_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_busy_in  = rsp_busy_ff;
      div_start    = 1'b0;

      // Drop the response once the receiver takes the beat.
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               fin_in   = 1'b0;
               state_in = ST_OUT;
               if (req_bus.req_type == REQ_START) begin
                  // Restart from the start level.
                  time_acc_in = '0;
                  level_in    = start_clamped;
                  armed_in    = 1'b1;
               end else if (armed_ff) begin
                  time_acc_in = t_sat;
                  if (t_sat == dur) begin
                     // Progress reaches one (also for a zero duration): snap and disarm.
                     armed_in = 1'b0;
                     fin_in   = 1'b1;
                     level_in = (fade_mode_ff == MODE_FADE_IN) ? target_clamped : '0;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               // Disarmed tick: hold the level.
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               prog_in  = div_quotient;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(mul_level) * PROD_W'(mul_factor);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            level_in = clamp_level(prod_ff[PROG_BITS +: LEVEL_BITS]);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Load the output register when it is empty or being drained.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               rsp_fin_in   = fin_ff;
               rsp_busy_in  = armed_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_acc_ff  <= '0;
         level_ff     <= '0;
         armed_ff     <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_acc_ff  <= time_acc_in;
         level_ff     <= level_in;
         armed_ff     <= armed_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prog_ff      <= prog_in;
      prod_ff      <= prod_in;
      rsp_level_ff <= rsp_level_in;
      rsp_fin_ff   <= rsp_fin_in;
      rsp_busy_ff  <= rsp_busy_in;
   end

   // Hold off requests while reset is asserted.
   assign req_bus.ready    = (state_ff == ST_IDLE) && !reset;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.level    = rsp_level_ff;
   assign rsp_bus.finished = rsp_fin_ff;
   assign rsp_bus.busy_res = rsp_busy_ff;

endmodule
`default_nettype wire
